[sv/aaf_pkg.sv]
// package for the 8080-style accumulator alu with flags
// holds operation codes, flag type and shared helpers; no dependencies
package aaf_pkg;

  localparam int DATA_W   = 8;
  localparam int ACTION_W = 5;
  localparam int MODE_W   = 2;

  localparam logic [ACTION_W-1:0] ACT_ADD = 5'd0;
  localparam logic [ACTION_W-1:0] ACT_ADC = 5'd1;
  localparam logic [ACTION_W-1:0] ACT_SUB = 5'd2;
  localparam logic [ACTION_W-1:0] ACT_SBB = 5'd3;
  localparam logic [ACTION_W-1:0] ACT_ANA = 5'd4;
  localparam logic [ACTION_W-1:0] ACT_XRA = 5'd5;
  localparam logic [ACTION_W-1:0] ACT_ORA = 5'd6;
  localparam logic [ACTION_W-1:0] ACT_CMP = 5'd7;
  localparam logic [ACTION_W-1:0] ACT_RLC = 5'd8;
  localparam logic [ACTION_W-1:0] ACT_RRC = 5'd9;
  localparam logic [ACTION_W-1:0] ACT_RAL = 5'd10;
  localparam logic [ACTION_W-1:0] ACT_RAR = 5'd11;
  localparam logic [ACTION_W-1:0] ACT_DAA = 5'd12;
  localparam logic [ACTION_W-1:0] ACT_CMA = 5'd13;
  localparam logic [ACTION_W-1:0] ACT_STC = 5'd14;
  localparam logic [ACTION_W-1:0] ACT_CMC = 5'd15;
  localparam logic [ACTION_W-1:0] ACT_EXT = 5'd16;

  localparam logic [MODE_W-1:0] MODE_INR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DCR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd2;

  localparam logic [DATA_W-1:0] DAA_LO_ADJ = 8'h06;
  localparam logic [DATA_W-1:0] DAA_HI_ADJ = 8'h60;
  localparam logic [3:0]        BCD_MAX    = 4'h9;

  typedef struct packed {
    logic sign;
    logic zero;
    logic parity;
    logic carry;
    logic half_carry;
  } flags_t;

  function automatic flags_t szp_flags(input logic [DATA_W-1:0] v, input logic carry,
                                       input logic half_carry);
    flags_t f;
    f.sign       = v[DATA_W-1];
    f.zero       = (v == '0);
    f.parity     = ~(^v);
    f.carry      = carry;
    f.half_carry = half_carry;
    return f;
  endfunction

  function automatic logic is_step_op(input logic [ACTION_W-1:0] action,
                                      input logic [MODE_W-1:0] mode);
    return (action == ACT_EXT) && ((mode == MODE_INR) || (mode == MODE_DCR));
  endfunction

endpackage

[sv/aaf_if.sv]
// valid/ready channel interfaces for the accumulator alu
// depends on aaf_pkg for widths
interface aaf_cmd_if;
  import aaf_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [MODE_W-1:0]   operand_mode;
  logic [DATA_W-1:0]   operand;

  modport source (output valid, action, operand_mode, operand, input ready);
  modport sink   (input valid, action, operand_mode, operand, output ready);
endinterface

interface aaf_rsp_if;
  import aaf_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result;
  logic              flag_sign;
  logic              flag_zero;
  logic              flag_parity;
  logic              flag_carry;
  logic              flag_half_carry;

  modport source (output valid, result, flag_sign, flag_zero, flag_parity, flag_carry,
                  flag_half_carry, input ready);
  modport sink   (input valid, result, flag_sign, flag_zero, flag_parity, flag_carry,
                  flag_half_carry, output ready);
endinterface

[sv/accumulator_alu_with_flags_unit.sv]
// top level of the 8080-style accumulator alu: input register, datapath, result register
// an accepted item passes the input register, then the result register, before result valid
// one item per cycle if not stalled; accumulator and flags update as the result is registered
// the result register frees the input side while a result waits to be taken
// synchronous reset clears accumulator, flags and both stage valids
// depends on aaf_pkg, aaf_if and aaf_core
module accumulator_alu_with_flags_unit (
  input  logic clk,
  input  logic rst,
  aaf_cmd_if.sink   cmd,
  aaf_rsp_if.source rsp
);
  import aaf_pkg::*;

  logic                s1_valid;
  logic [ACTION_W-1:0] s1_action;
  logic [MODE_W-1:0]   s1_mode;
  logic [DATA_W-1:0]   s1_operand;
  logic                out_valid;
  logic [DATA_W-1:0]   out_result;
  flags_t              out_flags;
  logic [DATA_W-1:0]   acc;
  flags_t              flags;
  logic [DATA_W-1:0]   acc_next;
  flags_t              flags_next;
  logic [DATA_W-1:0]   result_next;
  logic                advance;

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_action  <= cmd.action;
      s1_mode    <= cmd.operand_mode;
      s1_operand <= cmd.operand;
    end
  end

  aaf_core u_core (
    .action       (s1_action),
    .operand_mode (s1_mode),
    .operand      (s1_operand),
    .acc          (acc),
    .flags        (flags),
    .acc_next     (acc_next),
    .flags_next   (flags_next),
    .result       (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= '0;
      flags     <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        acc       <= acc_next;
        flags     <= flags_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result_next;
      out_flags  <= flags_next;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.result          = out_result;
  assign rsp.flag_sign       = out_flags.sign;
  assign rsp.flag_zero       = out_flags.zero;
  assign rsp.flag_parity     = out_flags.parity;
  assign rsp.flag_carry      = out_flags.carry;
  assign rsp.flag_half_carry = out_flags.half_carry;

`ifndef NO_ASSERTIONS
  a_cmp_keeps_acc: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_action == ACT_CMP) |=> acc == $past(acc))
    else $error("compare changed the accumulator");

  a_step_keeps_acc: assert property (@(posedge clk) disable iff (rst)
    advance && is_step_op(s1_action, s1_mode) |=> acc == $past(acc))
    else $error("increment or decrement changed the accumulator");

  a_result_is_acc: assert property (@(posedge clk) disable iff (rst)
    advance && !is_step_op(s1_action, s1_mode) |=> rsp.result == acc)
    else $error("result differs from new accumulator");

  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp.valid && (out_flags == flags))
    else $error("reported flags differ from flag register");

  a_stc_sets_carry: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_action == ACT_STC) |=> flags.carry)
    else $error("set carry did not set carry");
`endif

endmodule

[sv/aaf_core.sv]
// combinational datapath: one alu operation on accumulator, flags and operand
// depends on aaf_pkg
module aaf_core (
  input  logic [aaf_pkg::ACTION_W-1:0] action,
  input  logic [aaf_pkg::MODE_W-1:0]   operand_mode,
  input  logic [aaf_pkg::DATA_W-1:0]   operand,
  input  logic [aaf_pkg::DATA_W-1:0]   acc,
  input  aaf_pkg::flags_t              flags,
  output logic [aaf_pkg::DATA_W-1:0]   acc_next,
  output aaf_pkg::flags_t              flags_next,
  output logic [aaf_pkg::DATA_W-1:0]   result
);
  import aaf_pkg::*;

  logic              is_sub;
  logic              cin;
  logic [DATA_W-1:0] b_eff;
  logic [DATA_W:0]   sum;
  logic [4:0]        low_sum;
  logic              add_carry;
  logic [DATA_W-1:0] step_val;
  logic [3:0]        lo_nib;
  logic [3:0]        hi_nib;
  logic              lo_adj;
  logic              hi_adj;
  logic [DATA_W-1:0] corr;
  logic [DATA_W-1:0] daa_val;
  logic [DATA_W-1:0] logic_val;

  // shared adder for add, subtract and compare
  always_comb begin
    is_sub = (action == ACT_SUB) || (action == ACT_SBB) || (action == ACT_CMP);
    case (action)
      ACT_ADC: cin = flags.carry;
      ACT_SUB: cin = 1'b1;
      ACT_SBB: cin = ~flags.carry;
      ACT_CMP: cin = 1'b1;
      default: cin = 1'b0;
    endcase
    b_eff     = is_sub ? ~operand : operand;
    sum       = {1'b0, acc} + {1'b0, b_eff} + {{DATA_W{1'b0}}, cin};
    low_sum   = {1'b0, acc[3:0]} + {1'b0, b_eff[3:0]} + {4'b0, cin};
    add_carry = is_sub ? ~sum[DATA_W] : sum[DATA_W];
  end

  // decimal adjust
  always_comb begin
    lo_nib  = acc[3:0];
    hi_nib  = acc[7:4];
    lo_adj  = (lo_nib > BCD_MAX) || flags.half_carry;
    hi_adj  = (hi_nib > BCD_MAX) || flags.carry || ((hi_nib >= BCD_MAX) && (lo_nib > BCD_MAX));
    corr    = (lo_adj ? DAA_LO_ADJ : '0) | (hi_adj ? DAA_HI_ADJ : '0);
    daa_val = acc + corr;
  end

  assign step_val = (operand_mode == MODE_INR) ? operand + 8'd1 : operand - 8'd1;

  always_comb begin
    acc_next   = acc;
    flags_next = flags;
    logic_val  = '0;
    case (action)
      ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBB: begin
        acc_next   = sum[DATA_W-1:0];
        flags_next = szp_flags(sum[DATA_W-1:0], add_carry, low_sum[4]);
      end
      ACT_CMP: begin
        flags_next = szp_flags(sum[DATA_W-1:0], add_carry, low_sum[4]);
      end
      ACT_ANA: begin
        logic_val  = acc & operand;
        acc_next   = logic_val;
        flags_next = szp_flags(logic_val, 1'b0, acc[3] | operand[3]);
      end
      ACT_XRA: begin
        logic_val  = acc ^ operand;
        acc_next   = logic_val;
        flags_next = szp_flags(logic_val, 1'b0, 1'b0);
      end
      ACT_ORA: begin
        logic_val  = acc | operand;
        acc_next   = logic_val;
        flags_next = szp_flags(logic_val, 1'b0, 1'b0);
      end
      ACT_RLC: begin
        acc_next         = {acc[DATA_W-2:0], acc[DATA_W-1]};
        flags_next.carry = acc[DATA_W-1];
      end
      ACT_RRC: begin
        acc_next         = {acc[0], acc[DATA_W-1:1]};
        flags_next.carry = acc[0];
      end
      ACT_RAL: begin
        acc_next         = {acc[DATA_W-2:0], flags.carry};
        flags_next.carry = acc[DATA_W-1];
      end
      ACT_RAR: begin
        acc_next         = {flags.carry, acc[DATA_W-1:1]};
        flags_next.carry = acc[0];
      end
      ACT_DAA: begin
        acc_next   = daa_val;
        flags_next = szp_flags(daa_val, flags.carry | hi_adj, acc[4] ^ corr[4] ^ daa_val[4]);
      end
      ACT_CMA: acc_next = ~acc;
      ACT_STC: flags_next.carry = 1'b1;
      ACT_CMC: flags_next.carry = ~flags.carry;
      ACT_EXT: begin
        case (operand_mode)
          MODE_INR, MODE_DCR: flags_next = szp_flags(step_val, flags.carry, flags.half_carry);
          MODE_LOAD:          acc_next   = operand;
          default:            acc_next   = acc;
        endcase
      end
      default: acc_next = acc;
    endcase
  end

  assign result = is_step_op(action, operand_mode) ? step_val : acc_next;

endmodule

[verif/tb_accumulator_alu_with_flags_unit.sv]
// testbench for accumulator_alu_with_flags_unit: directed and random item streams with
// bursty input, stalling output and a long output hold, checked against a local alu model
// depends on aaf_pkg, aaf_if and the rtl of the unit
module tb_accumulator_alu_with_flags_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import aaf_pkg::*;

  localparam int          HALF_PERIOD  = 5;
  localparam int          RESET_CYCLES = 12;
  localparam int unsigned LIMIT_CYCLES = 100000;
  localparam int unsigned HOLD_LEN     = 80;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int          DRAIN_CYCLES = 6;

  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 5'd17;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 5'd31;
  localparam logic [MODE_W-1:0]   MODE_SPARE   = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    flags_t            flags;
  } alu_out_t;

  logic clk = 1'b0;
  logic rst;

  aaf_cmd_if cmd_ch ();
  aaf_rsp_if rsp_ch ();

  accumulator_alu_with_flags_unit DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch.sink),
    .rsp (rsp_ch.source)
  );

  always #HALF_PERIOD clk = ~clk;

  // alu model state
  logic [DATA_W-1:0] acc_q = '0;
  flags_t            flg_q = '0;

  alu_out_t    pending_results[$];
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;

  // sender state
  int unsigned burst_left = 1;
  logic        steady     = 1'b0;
  logic        offering   = 1'b0;

  // long output hold
  logic        hold_go   = 1'b0;
  logic        hold_used = 1'b0;
  int unsigned hold_left = 0;

  function automatic flags_t with_szp(input flags_t f, input logic [DATA_W-1:0] v);
    flags_t      n;
    int unsigned ones;
    n        = f;
    ones     = $countones(v);
    n.sign   = v[DATA_W-1];
    n.zero   = (v == 0);
    n.parity = (ones % 2 == 0);
    return n;
  endfunction

  function automatic alu_out_t alu_step(input logic [ACTION_W-1:0] act,
                                        input logic [MODE_W-1:0] md,
                                        input logic [DATA_W-1:0] opnd);
    logic [DATA_W-1:0] a, opb, nv, corr, mix;
    logic [DATA_W:0]   sum;
    logic [4:0]        low_sum;
    logic              cin, is_sub, new_cy;
    flags_t            f;
    alu_out_t          o;
    a  = acc_q;
    f  = flg_q;
    nv = a;
    case (act)
      ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBB, ACT_CMP: begin
        is_sub = (act == ACT_SUB) || (act == ACT_SBB) || (act == ACT_CMP);
        opb    = is_sub ? ~opnd : opnd;
        if (act == ACT_ADD) cin = 1'b0;
        else if (act == ACT_ADC) cin = flg_q.carry;
        else if (act == ACT_SBB) cin = ~flg_q.carry;
        else cin = 1'b1;
        sum          = {1'b0, a} + {1'b0, opb} + {{DATA_W{1'b0}}, cin};
        low_sum      = {1'b0, a[3:0]} + {1'b0, opb[3:0]} + {4'b0, cin};
        f            = with_szp(f, sum[DATA_W-1:0]);
        f.carry      = sum[DATA_W] ^ is_sub;
        f.half_carry = low_sum[4];
        if (act != ACT_CMP) acc_q = sum[DATA_W-1:0];
      end
      ACT_ANA: begin
        acc_q        = a & opnd;
        f            = with_szp(f, acc_q);
        f.carry      = 1'b0;
        f.half_carry = a[3] | opnd[3];
      end
      ACT_XRA, ACT_ORA: begin
        acc_q        = (act == ACT_XRA) ? (a ^ opnd) : (a | opnd);
        f            = with_szp(f, acc_q);
        f.carry      = 1'b0;
        f.half_carry = 1'b0;
      end
      ACT_RLC: begin
        acc_q   = {a[6:0], a[7]};
        f.carry = a[7];
      end
      ACT_RRC: begin
        acc_q   = {a[0], a[7:1]};
        f.carry = a[0];
      end
      ACT_RAL: begin
        acc_q   = {a[6:0], flg_q.carry};
        f.carry = a[7];
      end
      ACT_RAR: begin
        acc_q   = {flg_q.carry, a[7:1]};
        f.carry = a[0];
      end
      ACT_DAA: begin
        corr   = '0;
        new_cy = f.carry;
        if (a[3:0] > BCD_MAX || f.half_carry) corr = corr | DAA_LO_ADJ;
        if (a[7:4] > BCD_MAX || f.carry || (a[7:4] >= BCD_MAX && a[3:0] > BCD_MAX)) begin
          corr   = corr | DAA_HI_ADJ;
          new_cy = 1'b1;
        end
        nv           = a + corr;
        mix          = a ^ corr ^ nv;
        f            = with_szp(f, nv);
        f.half_carry = mix[4];
        f.carry      = new_cy;
        acc_q        = nv;
      end
      ACT_CMA: acc_q = ~a;
      ACT_STC: f.carry = 1'b1;
      ACT_CMC: f.carry = ~f.carry;
      ACT_EXT: begin
        case (md)
          MODE_INR: begin
            nv = opnd + 8'd1;
            f  = with_szp(f, nv);
          end
          MODE_DCR: begin
            nv = opnd - 8'd1;
            f  = with_szp(f, nv);
          end
          MODE_LOAD: acc_q = opnd;
          default: ;
        endcase
      end
      default: ;
    endcase
    flg_q    = f;
    o.result = (act == ACT_EXT && (md == MODE_INR || md == MODE_DCR)) ? nv : acc_q;
    o.flags  = f;
    return o;
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [MODE_W-1:0] md,
                           input logic [DATA_W-1:0] opnd);
    cmd_ch.valid        <= 1'b1;
    cmd_ch.action       <= act;
    cmd_ch.operand_mode <= md;
    cmd_ch.operand      <= opnd;
    offering = 1'b1;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(alu_step(act, md, opnd));
    items_sent++;
    if (!steady) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        cmd_ch.valid <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 10);
      end
    end
  endtask

  task automatic finish_phase();
    if (offering) begin
      cmd_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_result();
    alu_out_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("unexpected item: result %02h", rsp_ch.result);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (rsp_ch.result !== want.result) begin
      $error("result: expected %02h actual %02h", want.result, rsp_ch.result);
      mismatches++;
    end
    if (rsp_ch.flag_sign !== want.flags.sign) begin
      $error("flag_sign: expected %b actual %b", want.flags.sign, rsp_ch.flag_sign);
      mismatches++;
    end
    if (rsp_ch.flag_zero !== want.flags.zero) begin
      $error("flag_zero: expected %b actual %b", want.flags.zero, rsp_ch.flag_zero);
      mismatches++;
    end
    if (rsp_ch.flag_parity !== want.flags.parity) begin
      $error("flag_parity: expected %b actual %b", want.flags.parity, rsp_ch.flag_parity);
      mismatches++;
    end
    if (rsp_ch.flag_carry !== want.flags.carry) begin
      $error("flag_carry: expected %b actual %b", want.flags.carry, rsp_ch.flag_carry);
      mismatches++;
    end
    if (rsp_ch.flag_half_carry !== want.flags.half_carry) begin
      $error("flag_half_carry: expected %b actual %b", want.flags.half_carry,
             rsp_ch.flag_half_carry);
      mismatches++;
    end
  endtask

  function automatic logic [DATA_W-1:0] bcd_byte();
    logic [3:0] hi, lo;
    if ($urandom_range(0, 7) == 0) return DATA_W'($urandom_range(0, 255));
    hi = 4'($urandom_range(0, 9));
    lo = 4'($urandom_range(0, 9));
    return {hi, lo};
  endfunction

  function automatic logic [DATA_W-1:0] edge_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return DATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_op();
    logic [ACTION_W-1:0] act;
    if ($urandom_range(0, 7) == 0) act = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    else act = ACTION_W'($urandom_range(ACT_ADD, ACT_EXT));
    send_item(act, MODE_W'($urandom_range(MODE_INR, MODE_SPARE)),
              DATA_W'($urandom_range(0, 255)));
  endtask

  task automatic test_add_sub_extremes();
    send_item(ACT_EXT, MODE_LOAD, 8'hFF);
    send_item(ACT_ADD, MODE_INR, 8'h01);
    send_item(ACT_ADC, MODE_DCR, 8'hFF);
    send_item(ACT_SUB, MODE_LOAD, 8'h00);
    send_item(ACT_SBB, MODE_SPARE, 8'h01);
    send_item(ACT_CMP, MODE_INR, 8'hFF);
    finish_phase();
  endtask

  task automatic test_logic_ops();
    send_item(ACT_ANA, MODE_INR, 8'h08);
    send_item(ACT_XRA, MODE_INR, 8'hFF);
    send_item(ACT_ORA, MODE_INR, 8'h00);
    send_item(ACT_ANA, MODE_INR, 8'h00);
    finish_phase();
  endtask

  task automatic test_rotates_and_carry();
    send_item(ACT_STC, MODE_INR, 8'h00);
    send_item(ACT_RLC, MODE_INR, 8'hFF);
    send_item(ACT_RRC, MODE_DCR, 8'h00);
    send_item(ACT_RAL, MODE_LOAD, 8'hFF);
    send_item(ACT_RAR, MODE_SPARE, 8'h00);
    send_item(ACT_CMC, MODE_INR, 8'h5A);
    send_item(ACT_CMA, MODE_INR, 8'hA5);
    finish_phase();
  endtask

  task automatic test_decimal_adjust();
    send_item(ACT_EXT, MODE_LOAD, 8'h99);
    send_item(ACT_ADD, MODE_INR, 8'h01);
    send_item(ACT_DAA, MODE_INR, 8'h00);
    finish_phase();
  endtask

  task automatic test_step_ops_and_spare_codes();
    send_item(ACT_EXT, MODE_INR, 8'hFF);
    send_item(ACT_EXT, MODE_DCR, 8'h00);
    send_item(ACT_EXT, MODE_SPARE, 8'h3C);
    send_item(ACT_SPARE_HI, MODE_SPARE, 8'hFF);
    send_item(ACT_SPARE_LO, MODE_INR, 8'h00);
    finish_phase();
  endtask

  task automatic test_output_hold();
    hold_go <= 1'b1;
    while (hold_left == 0) @(posedge clk);
    steady = 1'b1;
    repeat (24) send_random_op();
    steady = 1'b0;
    finish_phase();
  endtask

  task automatic test_random_stream();
    int unsigned start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          send_item(ACT_EXT, MODE_LOAD, bcd_byte());
          send_item($urandom_range(0, 1) ? ACT_ADC : ACT_ADD,
                    MODE_W'($urandom_range(MODE_INR, MODE_SPARE)), bcd_byte());
          send_item(ACT_DAA, MODE_W'($urandom_range(MODE_INR, MODE_SPARE)),
                    DATA_W'($urandom_range(0, 255)));
        end
        3, 4: begin
          send_item(ACT_EXT, MODE_LOAD, bcd_byte());
          send_item($urandom_range(0, 1) ? ACT_SBB : ACT_SUB,
                    MODE_W'($urandom_range(MODE_INR, MODE_SPARE)), bcd_byte());
          send_item(ACT_DAA, MODE_INR, DATA_W'($urandom_range(0, 255)));
        end
        5: begin
          repeat (3) send_item(ACT_EXT, MODE_W'($urandom_range(MODE_INR, MODE_DCR)),
                               edge_byte());
        end
        6: begin
          send_item($urandom_range(0, 1) ? ACT_STC : ACT_CMC, MODE_INR,
                    DATA_W'($urandom_range(0, 255)));
          repeat (3) send_item(ACTION_W'(ACT_RLC + $urandom_range(0, 3)),
                               MODE_W'($urandom_range(MODE_INR, MODE_SPARE)),
                               DATA_W'($urandom_range(0, 255)));
        end
        default: send_random_op();
      endcase
    end
    finish_phase();
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_go && !hold_used) begin
      hold_left <= HOLD_LEN;
      hold_used <= 1'b1;
    end
  end

  // output side: checks each item, then picks ready from a rotating stall pattern
  initial begin : result_monitor
    int unsigned tick;
    logic        take;
    rsp_ch.ready <= 1'b0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_result();
      tick++;
      case ((tick / 48) % 4)
        0: take = 1'b1;
        1: take = 1'($urandom_range(0, 1));
        2: take = (tick % 4 == 0);
        default: take = ($urandom_range(0, 7) != 0);
      endcase
      rsp_ch.ready <= take && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_accumulator_alu_with_flags_unit: errors");
      $finish;
    end
  end

  initial begin
    rst                 <= 1'b1;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.action       <= ACT_ADD;
    cmd_ch.operand_mode <= MODE_INR;
    cmd_ch.operand      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_add_sub_extremes();
    test_logic_ops();
    test_rotates_and_carry();
    test_decimal_adjust();
    test_step_ops_and_spare_codes();
    test_output_hold();
    test_random_stream();
    $display("sent %0d items, checked %0d results in %0d cycles", items_sent, results_seen,
             cycle_count);
    $display("all opcodes, spare codes, bcd chains and a %0d-cycle output hold", HOLD_LEN);
    if (mismatches == 0) begin
      $display("tb_accumulator_alu_with_flags_unit: clean");
    end else begin
      $display("tb_accumulator_alu_with_flags_unit: errors");
    end
    $finish;
  end

endmodule
